### design/tac_pkg.sv
// Shared package for the touch averaging and calibration block.
// Holds widths, reset values, register indexes, sequencer types and the
// structs passed between the accumulator, the divider and the top level.
package tac_pkg;

  localparam int unsigned TAC_PAIRS_DEFAULT = 4;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = SIZE_W;
  localparam int unsigned DIV_DVD_W  = 2 * SAMPLE_W;
  localparam int unsigned DIV_DVS_W  = SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] LEFT_RST   = 12'd200;
  localparam logic [SAMPLE_W-1:0] RIGHT_RST  = 12'd3800;
  localparam logic [SAMPLE_W-1:0] TOP_RST    = 12'd200;
  localparam logic [SAMPLE_W-1:0] BOTTOM_RST = 12'd3800;
  localparam logic [SIZE_W-1:0]   WIDTH_RST  = 13'd320;
  localparam logic [SIZE_W-1:0]   HEIGHT_RST = 13'd240;
  localparam logic [SIZE_W-1:0]   SIZE_MAX   = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT   = 3'd0,
    CFG_RIGHT  = 3'd1,
    CFG_TOP    = 3'd2,
    CFG_BOTTOM = 3'd3,
    CFG_WIDTH  = 3'd4,
    CFG_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_AVG_X,
    OP_AVG_Y,
    OP_COL,
    OP_ROW
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_LAUNCH,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic             last;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } acc_stat_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/tac_accum.sv
// Pair accumulator: running X and Y sums and the pair count of a group.
// Depends on tac_pkg for widths and the status struct.
module tac_accum #(
  parameter int unsigned PAIRS_AVERAGED = tac_pkg::TAC_PAIRS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic [tac_pkg::SAMPLE_W-1:0]  sample_xchan_i,
  input  logic [tac_pkg::SAMPLE_W-1:0]  sample_ychan_i,
  output tac_pkg::acc_stat_t            stat_o
);
  import tac_pkg::*;

  localparam int unsigned CNT_W = (PAIRS_AVERAGED > 1) ? $clog2(PAIRS_AVERAGED) : 1;

  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_x_nxt, sum_y_nxt;
  logic             last;

  assign sum_x_nxt = sum_x_q + SUM_W'(sample_xchan_i);
  assign sum_y_nxt = sum_y_q + SUM_W'(sample_ychan_i);
  assign last      = (cnt_q == CNT_W'(PAIRS_AVERAGED - 1));

  assign stat_o.last  = last;
  assign stat_o.sum_x = sum_x_nxt;
  assign stat_o.sum_y = sum_y_nxt;

  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (acc_i) begin
      if (last) begin
        sum_x_d = '0;
        sum_y_d = '0;
        cnt_d   = '0;
      end else begin
        sum_x_d = sum_x_nxt;
        sum_y_d = sum_y_nxt;
        cnt_d   = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### design/tac_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tac_pkg for operand widths and the request and response structs.
module tac_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tac_pkg::div_req_t req_i,
  output tac_pkg::div_rsp_t rsp_o
);
  import tac_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_DVD_W + 1);

  logic                 busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_DVS_W-1:0] dvs_q, dvs_d;
  logic [DIV_DVS_W-1:0] rem_q, rem_d;
  logic [DIV_DVS_W:0]   rem_sh, rem_dif;
  logic                 fits;

  // The dividend register shifts left and collects quotient bits at the bottom.
  assign rem_sh  = {rem_q, dvd_q[DIV_DVD_W-1]};
  assign rem_dif = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    priority if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_DVD_W);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIV_DVD_W-2:0], fits};
      rem_d = fits ? rem_dif[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

### design/touch_average_and_calibrate_unit.sv
// Top level of the touch averaging and calibration block.
// Depends on tac_pkg, tac_accum and tac_div.
//
// Each accepted word is one X/Y pair of 12-bit touch samples. Words that do
// not close a group are taken one per cycle while no computation is running.
// The word that closes a group of PAIRS_AVERAGED pairs starts a computation
// during which in_stall_o is high: four quotients (the two averages, then
// screen column and screen row) go through one shared 24-step restoring
// divider, each passing through operand setup, launch, the divide steps and
// result collection. The result word then waits in the output register while
// the next group's words are taken; only a closing word is held off until the
// previous result has gone. Screen column comes from the Y channel and screen
// row from the X channel, each clamped to the screen size. Configuration
// writes take effect at once and are meant for an idle block.
module touch_average_and_calibrate_unit #(
  parameter int unsigned PAIRS_AVERAGED = tac_pkg::TAC_PAIRS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [tac_pkg::SAMPLE_W-1:0]    sample_xchan_i,
  input  logic [tac_pkg::SAMPLE_W-1:0]    sample_ychan_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tac_pkg::SAMPLE_W-1:0]    screen_col_o,
  output logic [tac_pkg::SAMPLE_W-1:0]    screen_row_o,
  output logic [tac_pkg::SAMPLE_W-1:0]    avg_xchan_o,
  output logic [tac_pkg::SAMPLE_W-1:0]    avg_ychan_o,
  input  logic                            cfg_we_i,
  input  logic [tac_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tac_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import tac_pkg::*;

  function automatic logic [SAMPLE_W-1:0] size_m1(input logic [SIZE_W-1:0] size);
    logic [SAMPLE_W-1:0] res;
    priority if (size == '0) begin
      res = '0;
    end else if (size > SIZE_MAX) begin
      res = '1;
    end else begin
      res = SAMPLE_W'(size - SIZE_W'(1));
    end
    return res;
  endfunction

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [SAMPLE_W-1:0] left_q, left_d, right_q, right_d;
  logic [SAMPLE_W-1:0] top_q, top_d, bottom_q, bottom_d;
  logic [SIZE_W-1:0]   width_q, width_d, height_q, height_d;

  logic [SUM_W-1:0]     grp_x_q, grp_x_d, grp_y_q, grp_y_d;
  logic [SAMPLE_W-1:0]  avg_x_q, avg_x_d, avg_y_q, avg_y_d;
  logic [SAMPLE_W-1:0]  col_q, col_d, row_q, row_d;
  logic                 out_valid_q, out_valid_d;
  logic [DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [DIV_DVS_W-1:0] dvs_q, dvs_d;
  logic                 neg_q, neg_d, zspan_q, zspan_d;
  logic [SAMPLE_W-1:0]  sm1_q, sm1_d;

  acc_stat_t acc_stat;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      in_acc, out_acc;

  // Mapping operands for the axis selected by the current operation.
  logic [SAMPLE_W-1:0]  map_raw, map_e0, map_e1, d_mag, s_mag, map_sm1;
  logic [SIZE_W-1:0]    map_size;
  logic [SAMPLE_W:0]    diff, span;
  logic [DIV_DVD_W-1:0] prod;
  logic [SAMPLE_W-1:0]  mapped;

  tac_accum #(
    .PAIRS_AVERAGED(PAIRS_AVERAGED)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (in_acc),
    .sample_xchan_i (sample_xchan_i),
    .sample_ychan_i (sample_ychan_i),
    .stat_o         (acc_stat)
  );

  tac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && acc_stat.last);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign map_raw  = (op_q == OP_COL) ? avg_y_q : avg_x_q;
  assign map_e0   = (op_q == OP_COL) ? left_q  : top_q;
  assign map_e1   = (op_q == OP_COL) ? right_q : bottom_q;
  assign map_size = (op_q == OP_COL) ? width_q : height_q;
  assign map_sm1  = size_m1(map_size);

  assign diff  = {1'b0, map_raw} - {1'b0, map_e0};
  assign span  = {1'b0, map_e1} - {1'b0, map_e0};
  assign d_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
  assign s_mag = span[SAMPLE_W] ? SAMPLE_W'(-span) : span[SAMPLE_W-1:0];
  assign prod  = DIV_DVD_W'(d_mag) * DIV_DVD_W'(map_sm1);

  // A negative quotient truncates to zero or below, so it clamps to zero.
  always_comb begin
    priority if (zspan_q || neg_q) begin
      mapped = '0;
    end else if (div_rsp.quotient > DIV_DVD_W'(sm1_q)) begin
      mapped = sm1_q;
    end else begin
      mapped = div_rsp.quotient[SAMPLE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && acc_stat.last) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP:   state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_d = (op_q == OP_ROW) ? ST_IDLE : ST_PREP;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates.
  always_comb begin
    op_d        = op_q;
    grp_x_d     = grp_x_q;
    grp_y_d     = grp_y_q;
    avg_x_d     = avg_x_q;
    avg_y_d     = avg_y_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    neg_d       = neg_q;
    zspan_d     = zspan_q;
    sm1_d       = sm1_q;

    div_req.start    = (state_q == ST_LAUNCH);
    div_req.dividend = dvd_q;
    div_req.divisor  = dvs_q;

    if (out_acc) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && acc_stat.last) begin
          grp_x_d = acc_stat.sum_x;
          grp_y_d = acc_stat.sum_y;
          op_d    = OP_AVG_X;
        end
      end
      ST_PREP: begin
        unique case (op_q)
          OP_AVG_X: begin
            dvd_d = DIV_DVD_W'(grp_x_q);
            dvs_d = DIV_DVS_W'(PAIRS_AVERAGED);
          end
          OP_AVG_Y: begin
            dvd_d = DIV_DVD_W'(grp_y_q);
            dvs_d = DIV_DVS_W'(PAIRS_AVERAGED);
          end
          default: begin
            dvd_d   = prod;
            dvs_d   = s_mag;
            neg_d   = diff[SAMPLE_W] ^ span[SAMPLE_W];
            zspan_d = (map_e0 == map_e1);
            sm1_d   = map_sm1;
          end
        endcase
      end
      ST_LAUNCH: begin
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          unique case (op_q)
            OP_AVG_X: begin
              avg_x_d = div_rsp.quotient[SAMPLE_W-1:0];
              op_d    = OP_AVG_Y;
            end
            OP_AVG_Y: begin
              avg_y_d = div_rsp.quotient[SAMPLE_W-1:0];
              op_d    = OP_COL;
            end
            OP_COL: begin
              col_d = mapped;
              op_d  = OP_ROW;
            end
            OP_ROW: begin
              row_d       = mapped;
              out_valid_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration writes; indexes past the register list are dropped.
  always_comb begin
    left_d   = left_q;
    right_d  = right_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT:   left_d   = cfg_wdata_i[SAMPLE_W-1:0];
        CFG_RIGHT:  right_d  = cfg_wdata_i[SAMPLE_W-1:0];
        CFG_TOP:    top_d    = cfg_wdata_i[SAMPLE_W-1:0];
        CFG_BOTTOM: bottom_d = cfg_wdata_i[SAMPLE_W-1:0];
        CFG_WIDTH:  width_d  = cfg_wdata_i;
        CFG_HEIGHT: height_d = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_AVG_X;
      out_valid_q <= 1'b0;
      left_q      <= LEFT_RST;
      right_q     <= RIGHT_RST;
      top_q       <= TOP_RST;
      bottom_q    <= BOTTOM_RST;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      right_q     <= right_d;
      top_q       <= top_d;
      bottom_q    <= bottom_d;
      width_q     <= width_d;
      height_q    <= height_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_x_q <= grp_x_d;
    grp_y_q <= grp_y_d;
    avg_x_q <= avg_x_d;
    avg_y_q <= avg_y_d;
    col_q   <= col_d;
    row_q   <= row_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    neg_q   <= neg_d;
    zspan_q <= zspan_d;
    sm1_q   <= sm1_d;
  end

  assign out_valid_o  = out_valid_q;
  assign screen_col_o = col_q;
  assign screen_row_o = row_q;
  assign avg_xchan_o  = avg_x_q;
  assign avg_ychan_o  = avg_y_q;

endmodule

### design/tac_checker.sv
// Port-level checker for the touch averaging and calibration block.
// Depends on tac_pkg for widths; bound to the top level at the end of this file.
module tac_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [tac_pkg::SAMPLE_W-1:0] screen_col_o,
  input logic [tac_pkg::SAMPLE_W-1:0] screen_row_o,
  input logic [tac_pkg::SAMPLE_W-1:0] avg_xchan_o,
  input logic [tac_pkg::SAMPLE_W-1:0] avg_ychan_o
);
  import tac_pkg::*;

  // A stalled result word keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(screen_col_o) &&
      $stable(screen_row_o) && $stable(avg_xchan_o) && $stable(avg_ychan_o))
    else $error("result word changed while stalled");

  // A result only appears after the block has been busy computing it.
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a busy period");

  // No accepted input word turns into a result on the very next cycle.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared directly after an input word");

  // A taken result is not repeated on the next cycle.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result word repeated after it was taken");

endmodule

bind touch_average_and_calibrate_unit tac_checker u_tac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .screen_col_o (screen_col_o),
  .screen_row_o (screen_row_o),
  .avg_xchan_o  (avg_xchan_o),
  .avg_ychan_o  (avg_ychan_o)
);

### tb/sv/tb_top.sv
// Self-checking bench for touch_average_and_calibrate_unit: drives X/Y sample pairs and
// calibration writes, predicts each averaged, calibrated point and compares it on the output.
// Depends on tac_pkg and the unit itself.
module tb_top;
  import tac_pkg::*;

  localparam int unsigned PAIRS           = TAC_PAIRS_DEFAULT;
  localparam int          SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
  localparam int unsigned GROUPS_PER_PASS = 49;
  localparam int unsigned SETTLE_CYCLES   = 130;
  localparam int unsigned HOLD_OFF_CYCLES = 450;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned IDLE_PERCENT    = 27;
  localparam int unsigned MAX_REPORTS     = 10;
  // Indexes beyond the register file; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] col;
    logic [SAMPLE_W-1:0] row;
    logic [SAMPLE_W-1:0] avg_x;
    logic [SAMPLE_W-1:0] avg_y;
  } touch_point_t;

  class touch_calib_scoreboard;
    logic [SAMPLE_W-1:0] left_edge, right_edge, top_edge, bottom_edge;
    logic [SIZE_W-1:0]   width, height;
    logic [SUM_W-1:0]    x_sum, y_sum;
    int unsigned         pair_count;
    touch_point_t        pending_points[$];
    int unsigned         mismatches, points_checked, pairs_noted;

    function new();
      left_edge   = LEFT_RST;
      right_edge  = RIGHT_RST;
      top_edge    = TOP_RST;
      bottom_edge = BOTTOM_RST;
      width       = WIDTH_RST;
      height      = HEIGHT_RST;
      x_sum       = '0;
      y_sum       = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LEFT:   left_edge   = data[SAMPLE_W-1:0];
        CFG_RIGHT:  right_edge  = data[SAMPLE_W-1:0];
        CFG_TOP:    top_edge    = data[SAMPLE_W-1:0];
        CFG_BOTTOM: bottom_edge = data[SAMPLE_W-1:0];
        CFG_WIDTH:  width       = data;
        CFG_HEIGHT: height      = data;
        default: ;
      endcase
    endfunction

    // Two-point linear map; the quotient truncates toward zero before clamping.
    function logic [SAMPLE_W-1:0] calibrate_axis(logic [SAMPLE_W-1:0] raw,
                                                 logic [SAMPLE_W-1:0] e0,
                                                 logic [SAMPLE_W-1:0] e1,
                                                 logic [SIZE_W-1:0] size);
      longint r, a, b, sz, q;
      r  = raw;
      a  = e0;
      b  = e1;
      sz = size;
      if (sz < 1) sz = 1;
      if (sz > SIZE_MAX) sz = SIZE_MAX;
      if (a == b) return '0;
      q = (r - a) * (sz - 1) / (b - a);
      if (q < 0) q = 0;
      else if (q >= sz) q = sz - 1;
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_pair(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y);
      touch_point_t p;
      pairs_noted++;
      x_sum = x_sum + SUM_W'(x);
      y_sum = y_sum + SUM_W'(y);
      pair_count++;
      if (pair_count < PAIRS) return;
      p.avg_x = SAMPLE_W'(x_sum / PAIRS);
      p.avg_y = SAMPLE_W'(y_sum / PAIRS);
      p.col   = calibrate_axis(p.avg_y, left_edge, right_edge, width);
      p.row   = calibrate_axis(p.avg_x, top_edge, bottom_edge, height);
      pending_points.push_back(p);
      x_sum      = '0;
      y_sum      = '0;
      pair_count = 0;
    endfunction

    function void check_point(touch_point_t got);
      touch_point_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected point col %0d row %0d avg_x %0d avg_y %0d", $time,
                   got.col, got.row, got.avg_x, got.avg_y);
        return;
      end
      want = pending_points.pop_front();
      points_checked++;
      if (got.col !== want.col || got.row !== want.row ||
          got.avg_x !== want.avg_x || got.avg_y !== want.avg_y) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: point %0d want/got col %0d/%0d row %0d/%0d ax %0d/%0d ay %0d/%0d",
                   $time, points_checked, want.col, got.col, want.row, got.row,
                   want.avg_x, got.avg_x, want.avg_y, got.avg_y);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   sample_xchan_i;
  logic [SAMPLE_W-1:0]   sample_ychan_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [SAMPLE_W-1:0]   screen_col_o;
  logic [SAMPLE_W-1:0]   screen_row_o;
  logic [SAMPLE_W-1:0]   avg_xchan_o;
  logic [SAMPLE_W-1:0]   avg_ychan_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  touch_calib_scoreboard sb = new();
  int unsigned cycles;
  int unsigned hold_off_cycles;
  int unsigned settings_used;
  bit          calm;

  touch_average_and_calibrate_unit #(
    .PAIRS_AVERAGED(PAIRS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_xchan_i(sample_xchan_i),
    .sample_ychan_i(sample_ychan_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .screen_col_o  (screen_col_o),
    .screen_row_o  (screen_row_o),
    .avg_xchan_o   (avg_xchan_o),
    .avg_ychan_o   (avg_ychan_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the edge, before any update made at that edge lands.
  initial begin
    touch_point_t seen;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (rst_ni && in_valid_i && !in_stall_o) sb.note_pair(sample_xchan_i, sample_ychan_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        seen.col   = screen_col_o;
        seen.row   = screen_row_o;
        seen.avg_x = avg_xchan_o;
        seen.avg_y = avg_ychan_o;
        sb.check_point(seen);
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: random stalls, none while calm, and a long hold-off when asked for.
  initial begin
    out_stall_i     = 1'b0;
    hold_off_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  task automatic send_pair(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    sample_xchan_i <= x;
    sample_ychan_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every outstanding point, then leave the divider time to finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Edge writes carry a random thirteenth bit, which the register must drop.
  task automatic program_calibration(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                                     input logic [SAMPLE_W-1:0] t, input logic [SAMPLE_W-1:0] b,
                                     input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    write_reg(CFG_LEFT,   {1'($urandom_range(1)), l});
    write_reg(CFG_RIGHT,  {1'($urandom_range(1)), r});
    write_reg(CFG_SPARE_LO + 3'($urandom_range(1)), CFG_DATA_W'($urandom));
    write_reg(CFG_TOP,    {1'($urandom_range(1)), t});
    write_reg(CFG_BOTTOM, {1'($urandom_range(1)), b});
    write_reg(CFG_WIDTH,  w);
    write_reg(CFG_HEIGHT, h);
    settings_used++;
  endtask

  function automatic int pick_base(logic [SAMPLE_W-1:0] e0, logic [SAMPLE_W-1:0] e1);
    int v;
    case ($urandom_range(7))
      0, 1:    v = e0;
      2, 3:    v = e1;
      4:       v = 0;
      5:       v = SAMPLE_MAX;
      default: v = $urandom_range(SAMPLE_MAX);
    endcase
    return v;
  endfunction

  function automatic logic [SAMPLE_W-1:0] jitter(int base, bit scatter);
    int v;
    if (scatter) return SAMPLE_W'($urandom_range(SAMPLE_MAX));
    v = base + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  // A group clustered around a calibration edge, a rail or a random point, or scattered over the full range.
  task automatic send_group();
    int bx, by;
    bit scatter;
    scatter = ($urandom_range(3) == 0);
    bx = pick_base(sb.top_edge, sb.bottom_edge);
    by = pick_base(sb.left_edge, sb.right_edge);
    repeat (PAIRS) send_pair(jitter(bx, scatter), jitter(by, scatter));
  endtask

  initial begin
    logic [SAMPLE_W-1:0] l, r, t, b;
    logic [SIZE_W-1:0]   w, h;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_xchan_i = '0;
    sample_ychan_i = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    calm           = 1'b0;
    settings_used  = 1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration: both rails, the exact edges, alternating bits and truncation.
    repeat (PAIRS) send_pair(12'd0, 12'd0);
    repeat (PAIRS) send_pair(12'hFFF, 12'hFFF);
    repeat (PAIRS) send_pair(12'd200, 12'd3800);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h555, 12'hAAA);
    send_pair(12'd1, 12'd2);
    send_pair(12'd2, 12'd1);

    // Rewrite the calibration with half a group summed: equal column edges, inverted
    // row edges with a masked top bit, zero width and an oversized height.
    send_pair(12'd3800, 12'd200);
    send_pair(12'd3799, 12'd201);
    settle();
    write_reg(CFG_LEFT, 13'd1000);
    write_reg(CFG_RIGHT, 13'd1000);
    write_reg(CFG_TOP, 13'h1FA0);
    write_reg(CFG_BOTTOM, 13'd100);
    write_reg(CFG_WIDTH, 13'd0);
    write_reg(CFG_HEIGHT, 13'h1FFF);
    write_reg(CFG_SPARE_LO, 13'd0);
    write_reg(CFG_SPARE_HI, 13'h1FFF);
    settings_used++;
    send_pair(12'd100, 12'd1000);
    send_pair(12'd102, 12'd1000);
    send_pair(12'hFFF, 12'd0);
    send_pair(12'hFFF, 12'hFFF);
    send_pair(12'd50, 12'd999);
    send_pair(12'd0, 12'd1001);

    for (int pass = 0; pass < 8; pass++) begin
      settle();
      l = SAMPLE_W'($urandom);
      r = SAMPLE_W'($urandom);
      t = SAMPLE_W'($urandom);
      b = SAMPLE_W'($urandom);
      w = SIZE_W'($urandom_range(1, SIZE_MAX));
      h = SIZE_W'($urandom_range(1, SIZE_MAX));
      case (pass)
        0: program_calibration(12'd0, 12'hFFF, 12'd0, 12'hFFF, SIZE_MAX, SIZE_MAX);
        1: program_calibration(l, r, t, b, 13'd1, 13'd1);
        2: program_calibration(12'hFFF, 12'd0, 12'hFFF, 12'd0, WIDTH_RST, HEIGHT_RST);
        3: program_calibration(l, r, t, b, SIZE_W'($urandom), SIZE_W'($urandom));
        5: program_calibration(l, l, t, b, w, h);
        6: program_calibration(l, r, t, b, 13'd0, SIZE_W'($urandom_range(SIZE_MAX + 1, 8191)));
        7: program_calibration(l | 12'd1, (l | 12'd1) - 12'd1, t & 12'hFFE, (t & 12'hFFE) + 12'd1,
                              SIZE_MAX, SIZE_MAX);
        default: program_calibration(l, r, t, b, w, h);
      endcase
      // The sender keeps offering while the output is held, so the unit backs up.
      if (pass == 2) hold_off_cycles = HOLD_OFF_CYCLES;
      calm = (pass == 4);
      repeat (GROUPS_PER_PASS) send_group();
      calm = 1'b0;
    end

    settle();
    $display("tb_top: %0d sample pairs over %0d calibration settings, %0d averaged points checked",
             sb.pairs_noted, settings_used, sb.points_checked);
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
